>>> src/pprv_pkg.sv
// Shared types and constants for the path prefix route validator.
package pprv_pkg;

	// Path limits
	localparam logic [7:0] PATH_LIMIT       = 8'd128;
	localparam logic [3:0] PREFIX_BYTES_MAX = 4'd8;

	// Characters of interest
	localparam logic [7:0] CH_SLASH     = 8'h2f;
	localparam logic [7:0] CH_DOT       = 8'h2e;
	localparam logic [7:0] CH_BACKSLASH = 8'h5c;
	localparam logic [7:0] CH_LOW       = 8'h20;
	localparam logic [7:0] CH_HIGH      = 8'h7e;
	localparam logic [7:0] CH_END       = 8'h00;

	// Configuration register map
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 64;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_FIRST_CHARS   = 3'd0,
		REG_FIRST_LENGTH  = 3'd1,
		REG_SECOND_CHARS  = 3'd2,
		REG_SECOND_LENGTH = 3'd3
	} pprv_reg_t;

	// Per-lane step control
	typedef struct packed {
		logic step;   // a byte is processed this cycle
		logic last;   // that byte is the terminating zero
	} pprv_lane_ctrl_t;

	// Per-lane verdict at the end of a path
	typedef struct packed {
		logic hit;
		logic ok;
	} pprv_lane_res_t;

endpackage

>>> src/pprv_if.sv
// Handshake channel interfaces: path bytes, results and configuration writes.
interface pprv_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] path_byte;

	modport source(output valid, output path_byte, input ready);
	modport sink(input valid, input path_byte, output ready);
endinterface

interface pprv_out_if;
	logic valid;
	logic ready;
	logic path_status;
	logic backend_choice;

	modport source(output valid, output path_status, output backend_choice, input ready);
	modport sink(input valid, input path_status, input backend_choice, output ready);
endinterface

interface pprv_cfg_if import pprv_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [CFG_DATA_W-1:0]  data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

>>> src/pprv_lane.sv
// One prefix lane: prefix match tracking and segment checks of the remainder.
module pprv_lane import pprv_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [63:0]     prefix_chars,
	input  logic [3:0]      prefix_length,
	input  pprv_lane_ctrl_t ctrl,
	input  logic [7:0]      path_byte,
	input  logic [7:0]      byte_pos,
	output pprv_lane_res_t  res
);

	logic       match_q;
	logic       hit_q;
	logic [1:0] seg_cls_q;
	logic       seg_dots_q;
	logic       rem_started_q;
	logic       rem_err_q;

	logic [3:0] plen;
	logic [3:0] plen_m1;
	logic [7:0] plen_ext;
	logic [7:0] pbyte_cur;
	logic [7:0] pbyte_last;
	logic       seg_bad;
	logic       allowed;

	// Clamp the prefix length and pick the prefix bytes in use
	assign plen       = (prefix_length > PREFIX_BYTES_MAX) ? PREFIX_BYTES_MAX : prefix_length;
	assign plen_m1    = plen - 4'd1;
	assign plen_ext   = {4'd0, plen};
	assign pbyte_cur  = prefix_chars[{byte_pos[2:0], 3'b000} +: 8];
	assign pbyte_last = prefix_chars[{plen_m1[2:0], 3'b000} +: 8];

	// Open segment is empty, "." or ".."
	assign seg_bad = (seg_cls_q == 2'd0) || (seg_dots_q && (seg_cls_q <= 2'd2));
	assign allowed = (path_byte >= CH_LOW) && (path_byte <= CH_HIGH) &&
		(path_byte != CH_BACKSLASH);

	// Verdict for a path that ends now
	always_comb begin
		res.hit = 1'b0;
		res.ok  = 1'b0;
		if ((byte_pos == plen_ext) && match_q) begin
			res.hit = 1'b1;
			res.ok  = !((plen != 4'd0) && (pbyte_last == CH_SLASH));
		end else if ((byte_pos > plen_ext) && hit_q) begin
			res.hit = 1'b1;
			res.ok  = !rem_err_q && !(rem_started_q && seg_bad);
		end
	end

	// Advance the lane state on each processed beat, clear it at the end byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q       <= 1'b1;
			hit_q         <= 1'b0;
			seg_cls_q     <= 2'd0;
			seg_dots_q    <= 1'b1;
			rem_started_q <= 1'b0;
			rem_err_q     <= 1'b0;
		end else if (ctrl.step) begin
			if (ctrl.last) begin
				match_q       <= 1'b1;
				hit_q         <= 1'b0;
				seg_cls_q     <= 2'd0;
				seg_dots_q    <= 1'b1;
				rem_started_q <= 1'b0;
				rem_err_q     <= 1'b0;
			end else if (byte_pos < plen_ext) begin
				if (path_byte != pbyte_cur) begin
					match_q <= 1'b0;
				end
			end else if (byte_pos == plen_ext) begin
				if (match_q && (path_byte == CH_SLASH)) begin
					hit_q         <= 1'b1;
					rem_started_q <= 1'b1;
					seg_cls_q     <= 2'd0;
					seg_dots_q    <= 1'b1;
				end else begin
					match_q <= 1'b0;
				end
			end else if (hit_q) begin
				if (path_byte == CH_SLASH) begin
					if (seg_bad) begin
						rem_err_q <= 1'b1;
					end
					seg_cls_q  <= 2'd0;
					seg_dots_q <= 1'b1;
				end else begin
					if (!allowed) begin
						rem_err_q <= 1'b1;
					end
					if (path_byte != CH_DOT) begin
						seg_dots_q <= 1'b0;
					end
					if (seg_cls_q != 2'd3) begin
						seg_cls_q <= seg_cls_q + 2'd1;
					end
				end
			end
		end
	end

endmodule

>>> src/path_prefix_route_validator.sv
// Top level of the path prefix route validator.
//
// Usage: a path enters on the path channel one byte per beat and ends with
// a zero byte. Each zero byte yields one beat on the result channel carrying
// path_status (0 accepted, 1 invalid) and backend_choice (0 first prefix,
// 1 second prefix, 0 when invalid). Other bytes yield nothing.
// The cfg channel writes the two mount prefixes and their lengths; it is
// always ready and should be used only between paths.
// Timing: a byte is registered in the input register and processed from
// there; the result of a zero byte is registered in the result register,
// from which the receiver takes it.
// Throughput: one byte per cycle, set by the single input register feeding
// two prefix lanes and the result register, unless a zero byte must wait.
// Reset clears the path state and sets both prefixes to zero bytes with
// length one. When the receiver stalls, the result register holds; bytes
// that cause no result keep flowing, and a terminating zero byte waits in
// the input register until the result register is free.
module path_prefix_route_validator import pprv_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	pprv_in_if.sink     path,
	pprv_out_if.source  result,
	pprv_cfg_if.sink    cfg
);

	logic [63:0] first_chars_q;
	logic [3:0]  first_len_q;
	logic [63:0] second_chars_q;
	logic [3:0]  second_len_q;

	logic        valid_s1;
	logic [7:0]  byte_s1;

	logic [7:0]  pos_q;
	logic        bad_q;

	logic        res_valid_q;
	logic        status_q;
	logic        backend_q;

	logic            is_end;
	logic            advance;
	logic [7:0]      pos_next;
	logic            pass;
	pprv_lane_ctrl_t lane_ctrl;
	pprv_lane_res_t  res0;
	pprv_lane_res_t  res1;

	// Configuration writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_chars_q  <= '0;
			first_len_q    <= 4'd1;
			second_chars_q <= '0;
			second_len_q   <= 4'd1;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_FIRST_CHARS:   first_chars_q  <= cfg.data;
				REG_FIRST_LENGTH:  first_len_q    <= cfg.data[3:0];
				REG_SECOND_CHARS:  second_chars_q <= cfg.data;
				REG_SECOND_LENGTH: second_len_q   <= cfg.data[3:0];
				default: ;
			endcase
		end
	end

	// Stage control: an end byte moves on only when the result slot frees
	assign is_end      = (byte_s1 == CH_END);
	assign advance     = valid_s1 && (!is_end || !res_valid_q || result.ready);
	assign path.ready  = !valid_s1 || advance;
	assign lane_ctrl.step = advance;
	assign lane_ctrl.last = is_end;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (path.ready) begin
			valid_s1 <= path.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (path.ready && path.valid) begin
			byte_s1 <= path.path_byte;
		end
	end

	// Byte position and start/length check
	assign pos_next = (pos_q == 8'hff) ? pos_q : pos_q + 8'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			bad_q <= 1'b0;
		end else if (advance) begin
			if (is_end) begin
				pos_q <= '0;
				bad_q <= 1'b0;
			end else begin
				pos_q <= pos_next;
				if (((pos_q == 8'd0) && (byte_s1 != CH_SLASH)) || (pos_next >= PATH_LIMIT)) begin
					bad_q <= 1'b1;
				end
			end
		end
	end

	// Prefix lanes
	pprv_lane u_lane0 (
		.clk           (clk),
		.arst_n        (arst_n),
		.prefix_chars  (first_chars_q),
		.prefix_length (first_len_q),
		.ctrl          (lane_ctrl),
		.path_byte     (byte_s1),
		.byte_pos      (pos_q),
		.res           (res0)
	);

	pprv_lane u_lane1 (
		.clk           (clk),
		.arst_n        (arst_n),
		.prefix_chars  (second_chars_q),
		.prefix_length (second_len_q),
		.ctrl          (lane_ctrl),
		.path_byte     (byte_s1),
		.byte_pos      (pos_q),
		.res           (res1)
	);

	// First matching prefix decides; the second is tried only on a miss
	assign pass = !bad_q && (pos_q != 8'd0) &&
		(res0.hit ? res0.ok : (res1.hit && res1.ok));

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && is_end) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && is_end) begin
			status_q  <= !pass;
			backend_q <= pass && !res0.hit;
		end
	end

	assign result.valid          = res_valid_q;
	assign result.path_status    = status_q;
	assign result.backend_choice = backend_q;

endmodule
